FILE: design/dsvb_pkg.sv
// Package for the detuned saw voice bank: widths, codes, shared word types
// and the 2^(k/256) table. No dependencies; every other design file uses it.
`timescale 1ns / 1ps
`default_nettype none

package dsvb_pkg;

    localparam int MAX_VOICES  = 1024;
    localparam int VOICE_W     = $clog2(MAX_VOICES);
    localparam int PHASE_W     = 24;
    localparam int INC_W       = PHASE_W - 1;
    localparam int CNT_W       = 11;
    localparam int BASE_W      = 24;
    localparam int DETUNE_W    = 16;
    localparam int RATE_W      = 18;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int TAB_W       = 31;
    localparam int NUM_W       = BASE_W + TAB_W;
    localparam int DELTA_W     = 26;
    localparam int OCT_W       = 16;
    localparam int SUM_W       = PHASE_W + VOICE_W;
    localparam int WIN_W       = INC_W + RATE_W;

    localparam logic [CFG_IDX_W-1:0] REG_BASE_FREQ   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DETUNE_STEP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOICE_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd3;

    localparam logic [BASE_W-1:0]   BASE_FREQ_RST   = 24'd112640;
    localparam logic [DETUNE_W-1:0] DETUNE_STEP_RST = 16'd0;
    localparam logic [CNT_W-1:0]    VOICE_COUNT_RST = 11'd1;
    localparam logic [RATE_W-1:0]   SAMPLE_RATE_RST = 18'd44100;

    localparam logic [PHASE_W-1:0] PHASE_MINUS_ONE = {1'b1, {(PHASE_W-1){1'b0}}};
    localparam logic [INC_W-1:0]   INC_MAX         = {INC_W{1'b1}};

    // Voice index handed into the increment pipeline.
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [VOICE_W-1:0] idx;
    } issue_t;

    // Finished increment for one voice.
    typedef struct packed {
        logic               valid;
        logic               last;
        logic [VOICE_W-1:0] idx;
        logic [INC_W-1:0]   inc;
    } inc_word_t;

    function automatic logic [63:0] isqrt64(input logic [63:0] val);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        int          i;
        v = val;
        r = 64'd0;
        b = 64'd1 << 62;
        for (i = 0; i < 32; i++)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // T[k] ~ 2^(k/256) in Q1.30, from repeated square roots of two.
    function automatic logic [255:0][TAB_W-1:0] build_pow_tab();
        logic [7:0][63:0]          roots;
        logic [255:0][TAB_W-1:0]   tab;
        logic [63:0]               t;
        logic [7:0]                kb;
        int                        j;
        int                        k;
        roots[7] = isqrt64(64'd2 << 60);
        for (j = 6; j >= 0; j--)
        begin
            roots[j] = isqrt64(roots[j+1] << 30);
        end
        for (k = 0; k < 256; k++)
        begin
            kb = k[7:0];
            t = 64'd1 << 30;
            for (j = 0; j < 8; j++)
            begin
                if (kb[j])
                begin
                    t = (t * roots[j] + (64'd1 << 29)) >> 30;
                end
            end
            tab[k] = t[TAB_W-1:0];
        end
        return tab;
    endfunction

    localparam logic [255:0][TAB_W-1:0] POW_TAB = build_pow_tab();

endpackage

`default_nettype wire

FILE: design/dsvb_inc_pipe.sv
// Increment pipeline: detune, octave split, table lookup, multiply, scaling
// shift and a 23-stage pipelined divider by the sample rate. Uses dsvb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsvb_inc_pipe (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire dsvb_pkg::issue_t               issue,
    input  wire logic [dsvb_pkg::BASE_W-1:0]    base_freq,
    input  wire logic [dsvb_pkg::DETUNE_W-1:0]  detune_step,
    input  wire logic [dsvb_pkg::RATE_W-1:0]    sample_rate,
    output dsvb_pkg::inc_word_t                 word
);

    localparam int STAGES = dsvb_pkg::INC_W;
    localparam int VW     = dsvb_pkg::VOICE_W;
    localparam int IW     = dsvb_pkg::INC_W;
    localparam int RW     = dsvb_pkg::RATE_W;
    localparam int NW     = dsvb_pkg::NUM_W;
    localparam int WW     = dsvb_pkg::WIN_W;
    localparam int OW     = dsvb_pkg::OCT_W;

    // Stage A: detune distance in Q.12 octaves.
    logic                          a_valid_reg;
    logic                          a_last_reg;
    logic [VW-1:0]                 a_idx_reg;
    logic [dsvb_pkg::DELTA_W-1:0]  a_delta_reg;
    logic [dsvb_pkg::DELTA_W:0]    a_prod;

    assign a_prod = ({1'b0, issue.idx} + {{VW{1'b0}}, 1'b1}) * {{(VW+1-dsvb_pkg::DETUNE_W > 0 ?
        VW+1-dsvb_pkg::DETUNE_W : 0){1'b0}}, detune_step};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= issue.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        a_last_reg  <= issue.last;
        a_idx_reg   <= issue.idx;
        a_delta_reg <= (issue.idx == '0) ? '0 : a_prod[dsvb_pkg::DELTA_W-1:0];
    end

    // Stage B: whole octaves and table fraction; odd voices go downward.
    logic                          b_valid_reg;
    logic                          b_last_reg;
    logic [VW-1:0]                 b_idx_reg;
    logic signed [OW-1:0]          b_oct_reg;
    logic [dsvb_pkg::TAB_W-1:0]    b_tab_reg;
    logic [13:0]                   b_q;
    logic [11:0]                   b_r;
    logic [12:0]                   b_frac_wide;
    logic [11:0]                   b_frac;
    logic signed [OW-1:0]          b_oct;

    assign b_q = a_delta_reg[25:12];
    assign b_r = a_delta_reg[11:0];
    assign b_frac_wide = 13'd4096 - {1'b0, b_r};

    always_comb
    begin
        if (!a_idx_reg[0])
        begin
            b_oct  = signed'({2'b00, b_q});
            b_frac = b_r;
        end
        else if (b_r == 12'd0)
        begin
            b_oct  = -signed'({2'b00, b_q});
            b_frac = 12'd0;
        end
        else
        begin
            b_oct  = -(signed'({2'b00, b_q}) + 16'sd1);
            b_frac = b_frac_wide[11:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        b_last_reg <= a_last_reg;
        b_idx_reg  <= a_idx_reg;
        b_oct_reg  <= b_oct;
        b_tab_reg  <= dsvb_pkg::POW_TAB[b_frac[11:4]];
    end

    // Stage C: base frequency times 2^(fraction).
    logic                  c_valid_reg;
    logic                  c_last_reg;
    logic [VW-1:0]         c_idx_reg;
    logic signed [OW-1:0]  c_oct_reg;
    logic [NW-1:0]         c_num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        c_last_reg <= b_last_reg;
        c_idx_reg  <= b_idx_reg;
        c_oct_reg  <= b_oct_reg;
        c_num_reg  <= NW'(base_freq) * NW'(b_tab_reg);
    end

    // Stage D: scale by 2^(oct-14). The window keeps the 23 bits that feed
    // the quotient plus 18 bits of starting remainder; anything above that
    // means the quotient has reached 1.0 and saturates.
    logic signed [OW:0]    d_shift;
    logic [OW:0]           d_mag;
    logic [NW+WW-1:0]      d_left;
    logic [NW-1:0]         d_right;
    logic [WW-1:0]         d_win;
    logic                  d_big;
    logic [RW-1:0]         d_rem0;

    assign d_shift = signed'({c_oct_reg[OW-1], c_oct_reg}) - 17'sd14;
    assign d_mag   = 17'(-d_shift);
    assign d_left  = {{WW{1'b0}}, c_num_reg} << d_shift[5:0];
    assign d_right = c_num_reg >> d_mag[5:0];

    always_comb
    begin
        if (!d_shift[OW])
        begin
            if (d_shift > 17'sd41)
            begin
                d_big = 1'b1;
                d_win = '0;
            end
            else
            begin
                d_big = |d_left[NW+WW-1:WW];
                d_win = d_left[WW-1:0];
            end
        end
        else if (d_mag >= 17'(NW))
        begin
            d_big = 1'b0;
            d_win = '0;
        end
        else
        begin
            d_big = |d_right[NW-1:WW];
            d_win = d_right[WW-1:0];
        end
    end

    assign d_rem0 = d_win[WW-1:IW];

    // Divider stage arrays; entry 0 is stage D.
    logic [STAGES:0]            dv_valid_reg;
    logic [STAGES:0]            dv_last_reg;
    logic [STAGES:0][VW-1:0]    dv_idx_reg;
    logic [STAGES:0][RW-1:0]    dv_rem_reg;
    logic [STAGES:0][IW-1:0]    dv_low_reg;
    logic [STAGES:0][IW-1:0]    dv_quo_reg;
    logic [STAGES:0]            dv_sat_reg;
    logic [STAGES:0]            dv_zero_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_valid_reg <= '0;
        end
        else
        begin
            dv_valid_reg <= {dv_valid_reg[STAGES-1:0], c_valid_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        dv_last_reg[0] <= c_last_reg;
        dv_idx_reg[0]  <= c_idx_reg;
        dv_rem_reg[0]  <= d_rem0;
        dv_low_reg[0]  <= d_win[IW-1:0];
        dv_quo_reg[0]  <= '0;
        dv_sat_reg[0]  <= d_big || (d_rem0 >= sample_rate);
        dv_zero_reg[0] <= (c_num_reg == '0);
    end

    genvar k;
    generate
        for (k = 1; k <= STAGES; k++)
        begin : g_div
            logic [RW:0] rin;
            logic [RW:0] diff;
            logic        ge;

            assign rin  = {dv_rem_reg[k-1], dv_low_reg[k-1][IW-1]};
            assign ge   = (rin >= {1'b0, sample_rate});
            assign diff = rin - {1'b0, sample_rate};

            always_ff @(posedge clk)
            begin
                dv_last_reg[k] <= dv_last_reg[k-1];
                dv_idx_reg[k]  <= dv_idx_reg[k-1];
                dv_rem_reg[k]  <= ge ? diff[RW-1:0] : rin[RW-1:0];
                dv_low_reg[k]  <= {dv_low_reg[k-1][IW-2:0], 1'b0};
                dv_quo_reg[k]  <= {dv_quo_reg[k-1][IW-2:0], ge};
                dv_sat_reg[k]  <= dv_sat_reg[k-1];
                dv_zero_reg[k] <= dv_zero_reg[k-1];
            end
        end
    endgenerate

    always_comb
    begin
        word.valid = dv_valid_reg[STAGES];
        word.last  = dv_last_reg[STAGES];
        word.idx   = dv_idx_reg[STAGES];
        if (dv_zero_reg[STAGES])
        begin
            word.inc = '0;
        end
        else if (dv_sat_reg[STAGES])
        begin
            word.inc = dsvb_pkg::INC_MAX;
        end
        else
        begin
            word.inc = dv_quo_reg[STAGES];
        end
    end

endmodule

`default_nettype wire

FILE: design/dsvb_phase_acc.sv
// Phase memory with its clearing pass, read-modify-write of each voice's
// phase and the running sum of new phases. Uses dsvb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsvb_phase_acc (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire dsvb_pkg::inc_word_t           word,
    output logic                               ready,
    output logic                               done,
    output logic [dsvb_pkg::SUM_W-1:0]         sum
);

    localparam int VW = dsvb_pkg::VOICE_W;
    localparam int PW = dsvb_pkg::PHASE_W;
    localparam int SW = dsvb_pkg::SUM_W;

    logic [PW-1:0] mem [dsvb_pkg::MAX_VOICES];

    logic          clr_busy_reg;
    logic [VW-1:0] clr_addr_reg;
    logic [PW-1:0] rd_data_reg;

    logic          p_valid_reg;
    logic          p_last_reg;
    logic [VW-1:0] p_idx_reg;
    logic [dsvb_pkg::INC_W-1:0] p_inc_reg;

    logic          done_reg;
    logic [SW-1:0] sum_reg;

    logic [PW:0]   raw;
    logic [PW-1:0] new_phase;
    logic          we;
    logic [VW-1:0] wa;
    logic [PW-1:0] wd;

    // The phase wraps to -1.0 once it reaches +1.0.
    assign raw = {rd_data_reg[PW-1], rd_data_reg} + {2'b00, p_inc_reg};
    assign new_phase = (!raw[PW] && raw[PW-1]) ? dsvb_pkg::PHASE_MINUS_ONE : raw[PW-1:0];

    assign we = clr_busy_reg || p_valid_reg;
    assign wa = clr_busy_reg ? clr_addr_reg : p_idx_reg;
    assign wd = clr_busy_reg ? dsvb_pkg::PHASE_MINUS_ONE : new_phase;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        rd_data_reg <= mem[word.idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
            p_valid_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
                if (clr_addr_reg == {VW{1'b1}})
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            p_valid_reg <= word.valid;
            done_reg    <= p_valid_reg && p_last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p_last_reg <= word.last;
        p_idx_reg  <= word.idx;
        p_inc_reg  <= word.inc;
        if (start)
        begin
            sum_reg <= '0;
        end
        else if (p_valid_reg)
        begin
            sum_reg <= sum_reg + {{(SW-PW){new_phase[PW-1]}}, new_phase};
        end
    end

    assign ready = !clr_busy_reg;
    assign done  = done_reg;
    assign sum   = sum_reg;

endmodule

`default_nettype wire

FILE: design/dsvb_mean_div.sv
// Iterative signed mean: the phase sum divided by the voice count,
// truncated toward zero, one quotient bit per cycle. Uses dsvb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dsvb_mean_div (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [dsvb_pkg::SUM_W-1:0]     sum,
    input  wire logic [dsvb_pkg::CNT_W-1:0]     cnt,
    output logic                                done,
    output logic [dsvb_pkg::PHASE_W-1:0]        mean
);

    localparam int SW = dsvb_pkg::SUM_W;
    localparam int CW = dsvb_pkg::CNT_W;
    localparam int PW = dsvb_pkg::PHASE_W;
    localparam int STEP_W = $clog2(SW + 1);

    logic              busy_reg;
    logic              done_reg;
    logic              neg_reg;
    logic [STEP_W-1:0] step_reg;
    logic [SW-1:0]     dvd_reg;
    logic [CW-1:0]     rem_reg;
    logic [CW-1:0]     cnt_reg;

    logic [SW-1:0]     mag;
    logic [CW:0]       rin;
    logic [CW:0]       diff;
    logic              ge;
    logic [PW-1:0]     quo;

    assign mag  = sum[SW-1] ? SW'(-sum) : sum;
    assign rin  = {rem_reg, dvd_reg[SW-1]};
    assign ge   = (rin >= {1'b0, cnt_reg});
    assign diff = rin - {1'b0, cnt_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && !start && (step_reg == STEP_W'(SW - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(SW - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // Quotient bits shift into the dividend register from the bottom.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= mag;
            rem_reg <= '0;
            cnt_reg <= cnt;
            neg_reg <= sum[SW-1];
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[SW-2:0], ge};
            rem_reg <= ge ? diff[CW-1:0] : rin[CW-1:0];
        end
    end

    assign quo  = dvd_reg[PW-1:0];
    assign done = done_reg;
    assign mean = neg_reg ? PW'(-quo) : quo;

endmodule

`default_nettype wire

FILE: design/detuned_saw_voice_bank.sv
// Detuned sawtooth voice bank. Each accepted tick word with tick set advances
// min(voice_count, 1024) saw phases and returns one sample word, their mean in
// signed Q1.23; a tick word with tick clear is taken and gives no sample. During
// a tick, voices stream one per cycle through the increment pipeline (27
// stages, ending in a pipelined divider by the sample rate) and the phase
// memory with its one read port and one write port, and the mean is then
// formed in a bit-serial divider. A voice count of zero answers 0 without
// running the voices. After reset the 1024-entry phase memory is cleared
// to -1.0, during which in_stall stays high. Configuration is to be written
// only while the block is idle; the block itself does not enforce this.
// Depends on dsvb_pkg, dsvb_inc_pipe, dsvb_phase_acc and dsvb_mean_div.
`timescale 1ns / 1ps
`default_nettype none

module detuned_saw_voice_bank (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write_en,
    input  wire logic [dsvb_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [dsvb_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic                              tick,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [dsvb_pkg::PHASE_W-1:0]    sample
);

    localparam int VW = dsvb_pkg::VOICE_W;
    localparam int CW = dsvb_pkg::CNT_W;
    localparam int PW = dsvb_pkg::PHASE_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RUN  = 3'd1;
    localparam logic [2:0] ST_WAIT = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_HOLD = 3'd4;

    logic [dsvb_pkg::BASE_W-1:0]   base_freq_reg;
    logic [dsvb_pkg::DETUNE_W-1:0] detune_step_reg;
    logic [CW-1:0]                 voice_count_reg;
    logic [dsvb_pkg::RATE_W-1:0]   sample_rate_reg;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [VW-1:0] idx_reg;
    logic [PW-1:0] res_reg;
    logic          out_valid_reg;
    logic [PW-1:0] out_sample_reg;

    logic [CW-1:0]           cnt_eff;
    logic                    accept;
    logic                    start_run;
    logic                    out_free;
    dsvb_pkg::issue_t        issue;
    dsvb_pkg::inc_word_t     word;
    logic                    mem_ready;
    logic                    sum_done;
    logic [dsvb_pkg::SUM_W-1:0] sum;
    logic                    div_done;
    logic [PW-1:0]           mean;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_freq_reg   <= dsvb_pkg::BASE_FREQ_RST;
            detune_step_reg <= dsvb_pkg::DETUNE_STEP_RST;
            voice_count_reg <= dsvb_pkg::VOICE_COUNT_RST;
            sample_rate_reg <= dsvb_pkg::SAMPLE_RATE_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                dsvb_pkg::REG_BASE_FREQ:   base_freq_reg   <= cfg_data[dsvb_pkg::BASE_W-1:0];
                dsvb_pkg::REG_DETUNE_STEP: detune_step_reg <= cfg_data[dsvb_pkg::DETUNE_W-1:0];
                dsvb_pkg::REG_VOICE_COUNT: voice_count_reg <= cfg_data[CW-1:0];
                dsvb_pkg::REG_SAMPLE_RATE: sample_rate_reg <= cfg_data[dsvb_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cnt_eff = (voice_count_reg > CW'(dsvb_pkg::MAX_VOICES)) ?
                     CW'(dsvb_pkg::MAX_VOICES) : voice_count_reg;

    assign in_stall  = !((state_reg == ST_IDLE) && mem_ready);
    assign accept    = in_valid && !in_stall;
    assign start_run = accept && tick && (cnt_eff != '0);
    assign out_free  = !out_valid_reg || !out_stall;

    assign issue.valid = (state_reg == ST_RUN);
    assign issue.idx   = idx_reg;
    assign issue.last  = ({1'b0, idx_reg} == (cnt_eff - 1'b1));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && tick)
                begin
                    state_next = (cnt_eff == '0) ? ST_HOLD : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (issue.last)
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                if (sum_done)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (start_run)
            begin
                idx_reg <= '0;
            end
            else if (state_reg == ST_RUN)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if ((state_reg == ST_HOLD) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && tick && (cnt_eff == '0))
        begin
            res_reg <= '0;
        end
        else if ((state_reg == ST_DIV) && div_done)
        begin
            res_reg <= mean;
        end
        if ((state_reg == ST_HOLD) && out_free)
        begin
            out_sample_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = signed'(out_sample_reg);

    dsvb_inc_pipe u_inc_pipe (
        .clk         (clk),
        .rst_n       (rst_n),
        .issue       (issue),
        .base_freq   (base_freq_reg),
        .detune_step (detune_step_reg),
        .sample_rate (sample_rate_reg),
        .word        (word)
    );

    dsvb_phase_acc u_phase_acc (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_run),
        .word  (word),
        .ready (mem_ready),
        .done  (sum_done),
        .sum   (sum)
    );

    dsvb_mean_div u_mean_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start ((state_reg == ST_WAIT) && sum_done),
        .sum   (sum),
        .cnt   (cnt_eff),
        .done  (div_done),
        .mean  (mean)
    );

endmodule

`default_nettype wire

FILE: tb/tb_detuned_saw_voice_bank.sv
// Testbench for detuned_saw_voice_bank: drives tick words and register writes,
// predicts every sample word and checks it. Depends on dsvb_pkg and the block.
`timescale 1ns / 1ps

class saw_bank_scoreboard;
    bit [63:0]   pow_frac[256];
    bit [23:0]   base_freq;
    bit [15:0]   detune_step;
    bit [10:0]   voice_count;
    bit [17:0]   sample_rate;
    longint      phase[1024];
    logic [23:0] expected_samples[$];
    int          mismatches;

    function new();
        bit [63:0] roots[8];
        bit [63:0] t;
        for (int i = 0; i < 1024; i++)
        begin
            phase[i] = -(64'sd1 <<< 23);
        end
        base_freq = 24'd112640;
        detune_step = 16'd0;
        voice_count = 11'd1;
        sample_rate = 18'd44100;
        mismatches = 0;
        roots[7] = floor_sqrt(64'd2 << 60);
        for (int j = 6; j >= 0; j--)
        begin
            roots[j] = floor_sqrt(roots[j+1] << 30);
        end
        for (int k = 0; k < 256; k++)
        begin
            t = 64'd1 << 30;
            for (int j = 0; j < 8; j++)
            begin
                if ((k >> j) & 1)
                begin
                    t = (t * roots[j] + (64'd1 << 29)) >> 30;
                end
            end
            pow_frac[k] = t;
        end
    endfunction

    function bit [63:0] floor_sqrt(bit [63:0] val);
        bit [63:0] v;
        bit [63:0] r;
        bit [63:0] b;
        v = val;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
        begin
            b = b >> 2;
        end
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function void write_reg(logic [dsvb_pkg::CFG_IDX_W-1:0] idx, bit [23:0] val);
        case (idx)
            dsvb_pkg::REG_BASE_FREQ:   base_freq = val;
            dsvb_pkg::REG_DETUNE_STEP: detune_step = val[15:0];
            dsvb_pkg::REG_VOICE_COUNT: voice_count = val[10:0];
            dsvb_pkg::REG_SAMPLE_RATE: sample_rate = val[17:0];
            default: ;
        endcase
    endfunction

    // Phase increment of one voice: base frequency shifted by its detune in
    // octaves, divided by the sample rate, saturated to just below 1.0.
    function bit [63:0] phase_step(int voice);
        bit [63:0] d;
        bit [63:0] q;
        bit [63:0] r;
        bit [63:0] frac;
        bit [63:0] num;
        bit [63:0] den;
        bit [63:0] lim;
        bit [63:0] v;
        bit [63:0] inc_max;
        longint    oct;
        inc_max = (64'd1 << 23) - 1;
        d = (voice == 0) ? 0 : 64'(voice + 1) * detune_step;
        q = d >> 12;
        r = d & 64'd4095;
        if (voice == 0 || voice % 2 == 0)
        begin
            oct = q;
            frac = r;
        end
        else if (r == 0)
        begin
            oct = -longint'(q);
            frac = 0;
        end
        else
        begin
            oct = -longint'(q + 1);
            frac = 4096 - r;
        end
        num = 64'(base_freq) * pow_frac[(frac >> 4) & 255];
        if (num == 0)
            return 0;
        if (sample_rate == 0)
            return inc_max;
        den = 64'(sample_rate) << 14;
        if (oct >= 0)
        begin
            if (oct >= 56)
                return inc_max;
            lim = 64'(sample_rate) << 37;
            lim = (lim + (64'd1 << oct) - 1) >> oct;
            if (num >= lim)
                return inc_max;
            v = (num << oct) / den;
        end
        else
        begin
            if (-oct >= 64)
                return 0;
            v = (num >> (-oct)) / den;
        end
        return (v > inc_max) ? inc_max : v;
    endfunction

    function void note_word(logic t);
        int     cnt;
        longint sum;
        longint p;
        longint mean;
        if (t !== 1'b1)
            return;
        cnt = (voice_count > 1024) ? 1024 : voice_count;
        if (cnt == 0)
        begin
            expected_samples.push_back(24'd0);
            return;
        end
        sum = 0;
        for (int i = 0; i < cnt; i++)
        begin
            p = phase[i] + longint'(phase_step(i));
            if (p >= (64'sd1 <<< 23))
                p = -(64'sd1 <<< 23);
            phase[i] = p;
            sum += p;
        end
        mean = sum / cnt;
        expected_samples.push_back(mean[23:0]);
    endfunction

    function void check_sample(logic [23:0] got);
        logic [23:0] want;
        if (expected_samples.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected sample word: %h", got);
            return;
        end
        want = expected_samples.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("sample mismatch: expected %h, got %h", want, got);
        end
    endfunction

    function int pending();
        return expected_samples.size();
    endfunction
endclass

module tb_detuned_saw_voice_bank;

    logic                                      clk;
    logic                                      rst_n;
    logic                                      cfg_write_en;
    logic [dsvb_pkg::CFG_IDX_W-1:0]            cfg_index;
    logic [dsvb_pkg::CFG_DATA_W-1:0]           cfg_data;
    logic                                      in_valid;
    logic                                      in_stall;
    logic                                      tick;
    logic                                      out_valid;
    logic                                      out_stall;
    logic signed [dsvb_pkg::PHASE_W-1:0]       sample;

    saw_bank_scoreboard sb;
    int sender_idle_pct;
    int receiver_idle_pct;

    detuned_saw_voice_bank uut (
        .clk(clk), .rst_n(rst_n), .cfg_write_en(cfg_write_en), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_valid(in_valid), .in_stall(in_stall), .tick(tick),
        .out_valid(out_valid), .out_stall(out_stall), .sample(sample)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Mismatches found");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            sb.note_word(tick);
        if (rst_n && out_valid && !out_stall)
            sb.check_sample(sample);
    end

    always @(negedge clk)
    begin
        out_stall <= ($urandom_range(99) < receiver_idle_pct);
    end

    task automatic write_reg(logic [dsvb_pkg::CFG_IDX_W-1:0] idx, logic [23:0] val);
        cfg_write_en = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_write_en = 1'b0;
    endtask

    task automatic send_tick(logic t);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        tick = t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Waits for all samples, then long enough for a tick-clear word to drain.
    task automatic drain();
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (1200) @(negedge clk);
    endtask

    task automatic run_phase(int p, logic [23:0] base, logic [23:0] det,
                             logic [23:0] cnt, logic [23:0] rate, int words);
        if (p < 5)
        begin
            sender_idle_pct = 24;
            receiver_idle_pct = 61;
        end
        else if (p < 10)
        begin
            sender_idle_pct = 61;
            receiver_idle_pct = 24;
        end
        else
        begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
        end
        write_reg(dsvb_pkg::REG_BASE_FREQ, base);
        write_reg(dsvb_pkg::REG_DETUNE_STEP, det);
        write_reg(dsvb_pkg::REG_VOICE_COUNT, cnt);
        write_reg(dsvb_pkg::REG_SAMPLE_RATE, rate);
        for (int i = 0; i < words; i++)
        begin
            send_tick($urandom_range(99) < 85);
            if (i == 15)
                drain();
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        sender_idle_pct = 0;
        receiver_idle_pct = 0;
        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = dsvb_pkg::REG_BASE_FREQ;
        cfg_data = '0;
        in_valid = 1'b0;
        tick = 1'b0;
        out_stall = 1'b0;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // Reset settings first, with one tick-clear word among them.
        sender_idle_pct = 24;
        receiver_idle_pct = 61;
        send_tick(1'b1);
        send_tick(1'b0);
        send_tick(1'b1);
        send_tick(1'b1);
        drain();
        run_phase(0, 24'hFFFFFF, 24'd65535, 24'd1024, 24'd192000, 3);
        run_phase(1, 24'd1, 24'd0, 24'd2047, 24'd8000, 2);
        run_phase(2, 24'd0, 24'd100, 24'd8, 24'd44100, 3);
        run_phase(3, 24'd112640, 24'd4096, 24'd5, 24'd0, 3);
        run_phase(4, 24'd112640, 24'd200, 24'd0, 24'd48000, 3);
        run_phase(5, 24'd5000000, 24'd1000, 24'd3, 24'd262143, 3);
        for (int p = 6; p < 14; p++)
        begin
            run_phase(p, $urandom_range(1, 24'hFFFFFF),
                      (p % 3 == 0) ? $urandom_range(0, 300) : $urandom_range(0, 65535),
                      $urandom_range(1, 24), $urandom_range(8000, 192000), 34);
        end

        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
